@@ hw/rtl/csh_pkg.sv @@
// Types and constants shared by the cone-splat height map modules.
`default_nettype none
package csh_pkg;

   localparam int CELL_W  = 22;
   localparam int GRAY_W  = 8;
   localparam int CFG_W   = 4;
   localparam int FUNC_W  = 2;
   localparam int LEVEL_W = 4;
   localparam int COORD_W = 9;
   localparam int OFS_W   = 11;
   localparam int SH_W    = 4;

   localparam logic [CELL_W-1:0] CELL_MAX  = '1;
   localparam logic [CFG_W-1:0]  CFG_RESET = 4'd9;

   typedef enum logic [1:0] {
      FUNC_SPLAT = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CMD_SPLAT,
      CMD_READ,
      CMD_CLEAR,
      CMD_EMPTY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [LEVEL_W-1:0]         level;
      logic [SH_W-1:0]            shift;
      logic signed [OFS_W-1:0]    org_x;
      logic signed [OFS_W-1:0]    org_y;
      logic [COORD_W-1:0]         read_x;
      logic [COORD_W-1:0]         read_y;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SPLAT,
      BK_DRAIN,
      BK_READ,
      BK_LOAD,
      BK_DIV,
      BK_RESP
   } back_state_type;

endpackage
`default_nettype wire

@@ hw/rtl/csh_front.sv @@
// Request front end: handshake and classification of each request into a queued command.
`default_nettype none
module csh_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csh_pkg::FUNC_W-1:0]    req_func,
   input  logic [csh_pkg::LEVEL_W-1:0]   req_level,
   input  logic [csh_pkg::COORD_W-1:0]   req_off_x,
   input  logic [csh_pkg::COORD_W-1:0]   req_off_y,
   input  logic signed [csh_pkg::COORD_W-1:0] req_rand_x,
   input  logic signed [csh_pkg::COORD_W-1:0] req_rand_y,
   input  logic [csh_pkg::COORD_W-1:0]   req_read_x,
   input  logic [csh_pkg::COORD_W-1:0]   req_read_y,
   input  logic [csh_pkg::CFG_W-1:0]     map_log2,
   input  logic                          init_busy,
   input  logic                          q_full,
   output logic                          push,
   output csh_pkg::cmd_type              push_cmd
);
   import csh_pkg::*;

   assign req_stall = q_full | init_busy;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      push_cmd        = '0;
      push_cmd.level  = req_level;
      push_cmd.shift  = map_log2 - req_level;
      push_cmd.org_x  = OFS_W'($signed({2'b00, req_off_x})) + OFS_W'(req_rand_x);
      push_cmd.org_y  = OFS_W'($signed({2'b00, req_off_y})) + OFS_W'(req_rand_y);
      push_cmd.read_x = req_read_x;
      push_cmd.read_y = req_read_y;
      case (func_type'(req_func))
         FUNC_SPLAT: begin
            if (req_level != '0 && req_level <= map_log2) begin
               push_cmd.kind = CMD_SPLAT;
            end else begin
               push_cmd.kind = CMD_EMPTY;
            end
         end
         FUNC_READ: begin
            if ((req_read_x >> map_log2) == '0 && (req_read_y >> map_log2) == '0) begin
               push_cmd.kind = CMD_READ;
            end else begin
               push_cmd.kind = CMD_EMPTY;
            end
         end
         FUNC_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         default: begin
            push_cmd.kind = CMD_EMPTY;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hw/rtl/csh_queue.sv @@
// Two-entry command queue between the front end and the back end.
`default_nettype none
module csh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csh_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output csh_pkg::cmd_type  head_cmd
);
   import csh_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_cmd   = ent_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/csh_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module csh_sqrt #(
   parameter int N     = 19,
   parameter int TAG_W = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic [2*N-1:0]     in_val,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_vld,
   output logic [N-1:0]       out_root,
   output logic [TAG_W-1:0]   out_tag,
   output logic               busy
);
   localparam int VW = 2 * N;

   logic             vld_ff  [N];
   logic [VW-1:0]    rem_ff  [N];
   logic [VW-1:0]    root_ff [N];
   logic [TAG_W-1:0] tag_ff  [N];

   genvar j;
   generate
      for (j = 0; j < N; j++) begin : g_stage
         localparam logic [VW-1:0] BIT = VW'(1) << (2 * (N - 1 - j));
         logic             vld_i;
         logic [VW-1:0]    rem_i;
         logic [VW-1:0]    root_i;
         logic [TAG_W-1:0] tag_i;
         logic [VW-1:0]    trial;
         if (j == 0) begin : g_first
            assign vld_i  = in_vld;
            assign rem_i  = in_val;
            assign root_i = '0;
            assign tag_i  = in_tag;
         end else begin : g_next
            assign vld_i  = vld_ff[j-1];
            assign rem_i  = rem_ff[j-1];
            assign root_i = root_ff[j-1];
            assign tag_i  = tag_ff[j-1];
         end
         assign trial = root_i + BIT;
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[j] <= 1'b0;
            end else begin
               vld_ff[j] <= vld_i;
            end
         end
         always_ff @(posedge clock) begin
            if (rem_i >= trial) begin
               rem_ff[j]  <= rem_i - trial;
               root_ff[j] <= (root_i >> 1) + BIT;
            end else begin
               rem_ff[j]  <= rem_i;
               root_ff[j] <= root_i >> 1;
            end
            tag_ff[j] <= tag_i;
         end
      end
   endgenerate

   assign out_vld  = vld_ff[N-1];
   assign out_root = root_ff[N-1][N-1:0];
   assign out_tag  = tag_ff[N-1];

   always_comb begin
      busy = 1'b0;
      for (int k = 0; k < N; k++) begin
         busy = busy | vld_ff[k];
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/csh_back.sv @@
// Back end: height map memory, splat pipeline, clear sweep, read with gray division, result register.
`default_nettype none
module csh_back #(
   parameter int MAP_LOG2  = 9,
   parameter int FRAC_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [csh_pkg::CFG_W-1:0]     map_log2,
   input  logic                          q_valid,
   input  csh_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   output logic                          init_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csh_pkg::CELL_W-1:0]    rsp_height,
   output logic [csh_pkg::GRAY_W-1:0]    rsp_gray_level,
   output logic [csh_pkg::CELL_W-1:0]    rsp_max_height,
   output logic                          rsp_saturated
);
   import csh_pkg::*;

   localparam int ML    = MAP_LOG2;
   localparam int AW    = 2 * ML;
   localparam int DEPTH = 1 << AW;
   localparam int N     = ML + FRAC_BITS;
   localparam int VW    = 2 * N;
   localparam int CW    = ((ML > 10) ? ML : 10) + 2;
   localparam int XW    = (ML > 9) ? ML : 9;
   localparam int SUMW  = ((N > CELL_W) ? N : CELL_W) + 1;
   localparam int TAG_W = AW + SH_W;
   localparam int NUM_W = CELL_W + GRAY_W;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic           init_ff, init_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [ML-1:0]  x_ff, x_in, y_ff, y_in;

   logic              p0_vld_ff, p0_vld_in;
   logic [ML-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [TAG_W-1:0]  p0_tag_ff, p0_tag_in;
   logic              p1_vld_ff;
   logic [AW-1:0]     sqx_ff, sqy_ff;
   logic [TAG_W-1:0]  p1_tag_ff;
   logic              p2_vld_ff;
   logic [VW-1:0]     d2v_ff;
   logic [TAG_W-1:0]  p2_tag_ff;
   logic              sq_vld;
   logic [N-1:0]      sq_root;
   logic [TAG_W-1:0]  sq_tag;
   logic              sq_busy;
   logic              p3_vld_ff;
   logic [N-1:0]      cone_ff, cone_in;
   logic [AW-1:0]     p3_addr_ff;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   logic [CELL_W-1:0] max_ff, max_in;
   logic              sat_ff, sat_in;
   logic [CELL_W-1:0] rem_ff, rem_in;
   logic [GRAY_W-1:0] quo_ff, quo_in;
   logic [GRAY_W-1:0] num_lo_ff, num_lo_in;
   logic [2:0]        div_cnt_ff, div_cnt_in;
   logic [CELL_W-1:0] height_ff, height_in;
   logic [GRAY_W-1:0] gray_ff, gray_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_height_ff, rsp_height_in;
   logic [GRAY_W-1:0] rsp_gray_ff, rsp_gray_in;
   logic [CELL_W-1:0] rsp_max_ff, rsp_max_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic              out_free;
   logic              pipe_busy;
   logic [ML-1:0]     span_mask;
   logic              last_x, last_y;
   logic [ML-1:0]     half;
   logic [ML-1:0]     u_pos, v_pos;
   logic signed [CW-1:0] cx, cy;
   logic              cell_in_map;
   logic [N-1:0]      hq, cone_full;
   logic [SUMW-1:0]   sum;
   logic [CELL_W-1:0] wval;
   logic              wsat;
   logic [NUM_W-1:0]  num;
   logic [CELL_W:0]   trial;
   logic [XW-1:0]     rxe, rye;

   assign init_busy = init_ff;
   assign q_pop     = (state_ff == BK_IDLE) && q_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pipe_busy = p0_vld_ff | p1_vld_ff | p2_vld_ff | sq_busy | p3_vld_ff;

   // Window walk: one window cell per cycle, x outer and y inner.
   always_comb begin
      logic [ML:0] span;
      span        = (ML+1)'(1) << cmd_ff.level;
      span_mask   = ML'(span - (ML+1)'(1));
      last_x      = (x_ff == span_mask);
      last_y      = (y_ff == span_mask);
      half        = ML'(1) << (map_log2 - 4'd1);
      u_pos       = x_ff << cmd_ff.shift;
      v_pos       = y_ff << cmd_ff.shift;
      dx_in       = (u_pos >= half) ? u_pos - half : half - u_pos;
      dy_in       = (v_pos >= half) ? v_pos - half : half - v_pos;
      cx          = CW'($signed({1'b0, x_ff})) + CW'(cmd_ff.org_x);
      cy          = CW'($signed({1'b0, y_ff})) + CW'(cmd_ff.org_y);
      cell_in_map = !cx[CW-1] && ((cx >> map_log2) == '0) &&
                    !cy[CW-1] && ((cy >> map_log2) == '0);
      p0_vld_in   = (state_ff == BK_SPLAT) && cell_in_map;
      p0_tag_in   = {cx[ML-1:0], cy[ML-1:0], cmd_ff.shift};
   end

   csh_sqrt #(
      .N     (N),
      .TAG_W (TAG_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (p2_vld_ff),
      .in_val   (d2v_ff),
      .in_tag   (p2_tag_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_tag  (sq_tag),
      .busy     (sq_busy)
   );

   always_comb begin
      hq        = N'(1) << (32'(map_log2) + FRAC_BITS - 1);
      cone_full = (sq_root < hq) ? hq - sq_root : '0;
      cone_in   = cone_full >> sq_tag[SH_W-1:0];
      sum       = SUMW'(rdata_ff) + SUMW'(cone_ff);
      wsat      = (sum > SUMW'(CELL_MAX));
      wval      = wsat ? CELL_MAX : CELL_W'(sum);
      rxe       = XW'(cmd_ff.read_x);
      rye       = XW'(cmd_ff.read_y);
      num       = {rdata_ff, {GRAY_W{1'b0}}} - NUM_W'(rdata_ff);
      trial     = {rem_ff, num_lo_ff[GRAY_W-1]};
   end

   always_comb begin
      if (state_ff == BK_READ) begin
         mem_raddr = {rxe[ML-1:0], rye[ML-1:0]};
      end else begin
         mem_raddr = sq_tag[TAG_W-1:SH_W];
      end
      if (state_ff == BK_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = p3_vld_ff;
         mem_waddr = p3_addr_ff;
         mem_wdata = wval;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (&clr_ff) begin
               state_in = init_ff ? BK_IDLE : BK_RESP;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  CMD_SPLAT: state_in = BK_SPLAT;
                  CMD_READ:  state_in = BK_READ;
                  CMD_CLEAR: state_in = BK_CLEAR;
                  default:   state_in = BK_RESP;
               endcase
            end
         end
         BK_SPLAT: begin
            if (last_x && last_y) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!pipe_busy) begin
               state_in = BK_RESP;
            end
         end
         BK_READ: begin
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            state_in = (max_ff == '0) ? BK_RESP : BK_DIV;
         end
         BK_DIV: begin
            if (div_cnt_ff == 3'd7) begin
               state_in = BK_RESP;
            end
         end
         BK_RESP: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in     = cmd_ff;
      init_in    = init_ff;
      clr_in     = clr_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      max_in     = max_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      num_lo_in  = num_lo_ff;
      div_cnt_in = div_cnt_ff;
      height_in  = height_ff;
      gray_in    = gray_ff;
      rsp_height_in = rsp_height_ff;
      rsp_gray_in   = rsp_gray_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (p3_vld_ff) begin
         if (wsat) begin
            sat_in = 1'b1;
         end
         if (wval > max_ff) begin
            max_in = wval;
         end
      end
      case (state_ff)
         BK_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               init_in = 1'b0;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               cmd_in    = q_cmd;
               x_in      = '0;
               y_in      = '0;
               height_in = '0;
               gray_in   = '0;
               if (q_cmd.kind == CMD_CLEAR) begin
                  max_in = '0;
                  sat_in = 1'b0;
               end
            end
         end
         BK_SPLAT: begin
            if (last_y) begin
               y_in = '0;
               x_in = x_ff + ML'(1);
            end else begin
               y_in = y_ff + ML'(1);
            end
         end
         BK_LOAD: begin
            height_in  = rdata_ff;
            rem_in     = num[NUM_W-1:GRAY_W];
            num_lo_in  = num[GRAY_W-1:0];
            quo_in     = '0;
            div_cnt_in = '0;
         end
         BK_DIV: begin
            if (trial >= {1'b0, max_ff}) begin
               rem_in = CELL_W'(trial - {1'b0, max_ff});
               quo_in = {quo_ff[GRAY_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CELL_W-1:0];
               quo_in = {quo_ff[GRAY_W-2:0], 1'b0};
            end
            num_lo_in  = num_lo_ff << 1;
            div_cnt_in = div_cnt_ff + 3'd1;
            gray_in    = quo_in;
         end
         BK_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = height_ff;
               rsp_gray_in   = gray_ff;
               rsp_max_in    = max_ff;
               rsp_sat_in    = sat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         max_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p0_vld_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         max_ff       <= max_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         p0_vld_ff    <= p0_vld_in;
         p1_vld_ff    <= p0_vld_ff;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      p0_tag_ff     <= p0_tag_in;
      sqx_ff        <= AW'(dx_ff) * AW'(dx_ff);
      sqy_ff        <= AW'(dy_ff) * AW'(dy_ff);
      p1_tag_ff     <= p0_tag_ff;
      d2v_ff        <= VW'(sqx_ff + sqy_ff) << (2 * FRAC_BITS);
      p2_tag_ff     <= p1_tag_ff;
      cone_ff       <= cone_in;
      p3_addr_ff    <= sq_tag[TAG_W-1:SH_W];
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      num_lo_ff     <= num_lo_in;
      div_cnt_ff    <= div_cnt_in;
      height_ff     <= height_in;
      gray_ff       <= gray_in;
      rsp_height_ff <= rsp_height_in;
      rsp_gray_ff   <= rsp_gray_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height     = rsp_height_ff;
   assign rsp_gray_level = rsp_gray_ff;
   assign rsp_max_height = rsp_max_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cone_splat_heightmap_top.sv @@
// Top level of the cone-splat height map: configuration register, front end, queue and back end.
// A splat covers 4^level cells, one map cell per cycle through the memory read-modify-write,
// and then waits for the square-root pipeline to drain.
// A read does a memory read and an 8-step gray division; a clear sweeps all 4^MAP_LOG2 cells.
// Reset is synchronous; afterwards the map is swept to zero, all 4^MAP_LOG2 cells,
// during which no request is accepted, while configuration writes are taken at once.
`default_nettype none
module cone_splat_heightmap_top #(
   parameter int MAP_LOG2  = 9,
   parameter int FRAC_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csh_pkg::CFG_W-1:0]     csr_map_log2,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csh_pkg::FUNC_W-1:0]    req_func,
   input  logic [csh_pkg::LEVEL_W-1:0]   req_level,
   input  logic [csh_pkg::COORD_W-1:0]   req_off_x,
   input  logic [csh_pkg::COORD_W-1:0]   req_off_y,
   input  logic signed [csh_pkg::COORD_W-1:0] req_rand_x,
   input  logic signed [csh_pkg::COORD_W-1:0] req_rand_y,
   input  logic [csh_pkg::COORD_W-1:0]   req_read_x,
   input  logic [csh_pkg::COORD_W-1:0]   req_read_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csh_pkg::CELL_W-1:0]    rsp_height,
   output logic [csh_pkg::GRAY_W-1:0]    rsp_gray_level,
   output logic [csh_pkg::CELL_W-1:0]    rsp_max_height,
   output logic                          rsp_saturated
);
   import csh_pkg::*;

   localparam logic [CFG_W-1:0] ML_MAX   = CFG_W'(MAP_LOG2);
   localparam logic [CFG_W-1:0] ML_RESET = (MAP_LOG2 < 9) ? CFG_W'(MAP_LOG2) : CFG_RESET;

   logic [CFG_W-1:0] map_log2_ff, map_log2_in;
   logic             init_busy;
   logic             q_full, push, pop, head_valid;
   cmd_type          push_cmd, head_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      map_log2_in = map_log2_ff;
      if (csr_valid && csr_ready) begin
         if (csr_map_log2 == '0) begin
            map_log2_in = CFG_W'(1);
         end else if (csr_map_log2 > ML_MAX) begin
            map_log2_in = ML_MAX;
         end else begin
            map_log2_in = csr_map_log2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_log2_ff <= ML_RESET;
      end else begin
         map_log2_ff <= map_log2_in;
      end
   end

   csh_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_level  (req_level),
      .req_off_x  (req_off_x),
      .req_off_y  (req_off_y),
      .req_rand_x (req_rand_x),
      .req_rand_y (req_rand_y),
      .req_read_x (req_read_x),
      .req_read_y (req_read_y),
      .map_log2   (map_log2_ff),
      .init_busy  (init_busy),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   csh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   csh_back #(
      .MAP_LOG2  (MAP_LOG2),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .map_log2       (map_log2_ff),
      .q_valid        (head_valid),
      .q_cmd          (head_cmd),
      .q_pop          (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_height     (rsp_height),
      .rsp_gray_level (rsp_gray_level),
      .rsp_max_height (rsp_max_height),
      .rsp_saturated  (rsp_saturated)
   );

   a_height_below_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_height <= rsp_max_height)
      else $error("Result height exceeds the running maximum.");

   a_gray_needs_height: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gray_level != '0) |-> rsp_height != '0)
      else $error("Non-zero gray level reported for a zero height.");

   a_no_request_in_sweep: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall)
      else $error("Request accepted during the reset sweep.");

   a_map_size_range: assert property (@(posedge clock) disable iff (reset)
      map_log2_ff >= CFG_W'(1) && map_log2_ff <= ML_MAX)
      else $error("Map size register out of range.");

endmodule
`default_nettype wire
